// ----- design/i2cps_pkg.sv -----
// Shared types, codes and phase table for the I2C phase sequencer.
package i2cps_pkg;

  // Operation codes as they arrive on the request beat
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_CACK  = 3'd6;

  // Read pattern: last phase, and the sampling sub-step within each bit
  localparam logic [5:0] READ_LAST_PHASE = 6'd33;
  localparam logic [1:0] READ_SUB_LOW    = 2'd1;
  localparam logic [1:0] READ_SUB_HIGH   = 2'd2;
  localparam logic [1:0] READ_SUB_SAMPLE = 2'd3;

  // Command being carried out by the back end; idle when none
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_CACK  = 3'd6
  } cmd_t;

  // Request beat
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } req_t;

  // Response beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       rejected;
  } rsp_t;

  // Classified item passed from front end to back end
  typedef struct packed {
    logic       is_cmd;
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // Number of phases in each command's line pattern
  function automatic logic [5:0] phase_len(input cmd_t cmd);
    logic [5:0] len;
    unique case (cmd)
      CMD_START: len = 6'd3;
      CMD_STOP:  len = 6'd3;
      CMD_WRITE: len = 6'd25;
      CMD_READ:  len = 6'd33;
      CMD_SACK:  len = 6'd5;
      CMD_CACK:  len = 6'd6;
      default:   len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- design/i2cps_front.sv -----
// Front end: decode the operation of each request beat into a tick or a command.
module i2cps_front import i2cps_pkg::*; (
  input  req_t  req,
  output item_t item
);

  // Classify the operation; code seven counts as a tick
  always_comb begin
    item.is_cmd    = 1'b1;
    item.cmd       = CMD_IDLE;
    item.data_byte = req.data_byte;
    item.ack_level = req.ack_level;
    item.sda_in    = req.sda_in;
    unique case (req.operation)
      OP_START: item.cmd = CMD_START;
      OP_STOP:  item.cmd = CMD_STOP;
      OP_WRITE: item.cmd = CMD_WRITE;
      OP_READ:  item.cmd = CMD_READ;
      OP_SACK:  item.cmd = CMD_SACK;
      OP_CACK:  item.cmd = CMD_CACK;
      default:  item.is_cmd = 1'b0;
    endcase
  end

endmodule

// ----- design/i2cps_queue.sv -----
// Two-entry queue of classified items between the front and back ends.
module i2cps_queue import i2cps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Occupancy stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue occupancy beyond depth");

  // Never pop an empty queue or push a full one
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

// ----- design/i2cps_back.sv -----
// Back end: step the command's line pattern per item and register the response beat.
module i2cps_back import i2cps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  item_t head_item,
  output logic  pop,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp
);

  cmd_t       cmd_held, cmd_held_next;
  logic [5:0] phase_count, phase_count_next;
  logic [5:0] phase;
  logic [5:0] phase_m1;
  logic [1:0] bit_step, bit_step_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] read_byte_reg, read_byte_reg_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       ack_reg, ack_reg_next;
  logic       ack_drive, ack_drive_next;
  logic       load;
  logic       advance;
  logic       done;
  logic       rej;

  // Take the head item whenever the response register is free or draining
  assign pop = head_valid && (!rsp_valid || !rsp_stall);

  assign load     = pop && head_item.is_cmd && (cmd_held == CMD_IDLE);
  assign advance  = pop && !head_item.is_cmd && (cmd_held != CMD_IDLE);
  assign phase    = phase_count + 6'd1;
  assign phase_m1 = phase_count;

  // Next command and phase
  always_comb begin
    cmd_held_next    = cmd_held;
    phase_count_next = phase_count;
    done             = 1'b0;
    rej              = 1'b0;
    if (pop && head_item.is_cmd) begin
      if (cmd_held != CMD_IDLE) begin
        rej = 1'b1;
      end else begin
        cmd_held_next    = head_item.cmd;
        phase_count_next = 6'd0;
      end
    end else if (advance) begin
      phase_count_next = phase;
      if (phase >= phase_len(cmd_held)) begin
        done             = 1'b1;
        cmd_held_next    = CMD_IDLE;
        phase_count_next = 6'd0;
      end
    end
  end

  // Line actions and data path for the current phase
  always_comb begin
    bit_step_next      = bit_step;
    shift_byte_next    = shift_byte;
    read_byte_reg_next = read_byte_reg;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    ack_reg_next       = ack_reg;
    ack_drive_next     = ack_drive;
    if (load) begin
      bit_step_next = 2'd0;
      case (head_item.cmd)
        CMD_WRITE: shift_byte_next = head_item.data_byte;
        CMD_READ:  shift_byte_next = 8'd0;
        CMD_SACK:  ack_drive_next  = head_item.ack_level;
        default:   ;
      endcase
    end else if (advance) begin
      unique case (cmd_held)
        CMD_START: begin
          if (phase == 6'd1) begin
            sda_reg_next = 1'b1;
            scl_reg_next = 1'b1;
          end else if (phase == 6'd2) begin
            sda_reg_next = 1'b0;
          end else begin
            scl_reg_next = 1'b0;
          end
        end
        CMD_STOP: begin
          if (phase == 6'd2) scl_reg_next = 1'b1;
          else if (phase == 6'd3) sda_reg_next = 1'b1;
        end
        CMD_WRITE: begin
          // Three sub-steps per bit: drive data, raise clock, drop clock
          if (phase >= 6'd2) begin
            bit_step_next = (bit_step == 2'd2) ? 2'd0 : bit_step + 2'd1;
            if (bit_step == 2'd0) begin
              sda_reg_next    = shift_byte[7];
              shift_byte_next = {shift_byte[6:0], 1'b0};
            end else if (bit_step == 2'd1) begin
              scl_reg_next = 1'b1;
            end else begin
              scl_reg_next = 1'b0;
            end
          end
        end
        CMD_READ: begin
          if (phase == READ_LAST_PHASE) begin
            scl_reg_next       = 1'b0;
            read_byte_reg_next = shift_byte;
          end else begin
            if (phase == 6'd1) sda_reg_next = 1'b1;
            if (phase_m1[1:0] == READ_SUB_LOW) begin
              scl_reg_next = 1'b0;
            end else if (phase_m1[1:0] == READ_SUB_HIGH) begin
              scl_reg_next = 1'b1;
            end else if (phase_m1[1:0] == READ_SUB_SAMPLE) begin
              shift_byte_next = {shift_byte[6:0], head_item.sda_in};
            end
          end
        end
        CMD_SACK: begin
          if (phase == 6'd1) begin
            scl_reg_next = 1'b0;
          end else if (phase == 6'd2) begin
            sda_reg_next = ~ack_drive;
            scl_reg_next = 1'b0;
          end else if (phase == 6'd3) begin
            scl_reg_next = 1'b1;
          end else if (phase == 6'd4) begin
            scl_reg_next = 1'b0;
          end else begin
            sda_reg_next = 1'b1;
          end
        end
        CMD_CACK: begin
          if (phase == 6'd1) sda_reg_next = 1'b1;
          else if (phase == 6'd2) scl_reg_next = 1'b0;
          else if (phase == 6'd3) scl_reg_next = 1'b1;
          else if (phase == 6'd4) ack_reg_next = ~head_item.sda_in;
          else if (phase == 6'd5) scl_reg_next = 1'b0;
          else sda_reg_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Hold sequencer state; pins reset released high
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held      <= CMD_IDLE;
      phase_count   <= 6'd0;
      bit_step      <= 2'd0;
      shift_byte    <= 8'd0;
      read_byte_reg <= 8'd0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      ack_reg       <= 1'b0;
      ack_drive     <= 1'b0;
    end else begin
      cmd_held      <= cmd_held_next;
      phase_count   <= phase_count_next;
      bit_step      <= bit_step_next;
      shift_byte    <= shift_byte_next;
      read_byte_reg <= read_byte_reg_next;
      scl_reg       <= scl_reg_next;
      sda_reg       <= sda_reg_next;
      ack_reg       <= ack_reg_next;
      ack_drive     <= ack_drive_next;
    end
  end

  // Register the response beat; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.scl_level    <= scl_reg_next;
      rsp.sda_level    <= sda_reg_next;
      rsp.busy_res     <= (cmd_held_next != CMD_IDLE);
      rsp.done_res     <= done;
      rsp.read_data    <= read_byte_reg_next;
      rsp.ack_received <= ack_reg_next;
      rsp.rejected     <= rej;
    end
  end

  // A finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |-> !rsp.busy_res)
    else $error("done reported while still busy");

  // A refused command never ends the running one
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.rejected |-> rsp.busy_res && !rsp.done_res)
    else $error("rejection while idle or on completion");

  // Phase never runs past the longest pattern
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase_count < READ_LAST_PHASE)
    else $error("phase counter beyond pattern length");

  // Idle sequencer keeps phase at zero
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    cmd_held == CMD_IDLE |-> phase_count == 6'd0)
    else $error("phase count set while idle");

endmodule

// ----- design/i2c_master_phase_sequencer.sv -----
// Top level of the I2C master phase sequencer: front end, item queue, back end.
//
//   beat   direction  handshake               payload
//   req    in         req_valid / req_stall   req_t: operation, data_byte, ack_level, sda_in
//   rsp    out        rsp_valid / rsp_stall   rsp_t: pins, busy, done, read byte, ack, reject
//
// One request beat per cycle while req_stall is low; once taken, each beat waits in the
// two-entry queue, then its response beat is held in the response register.
// The back end applies one phase per tick beat, so the queue and response register set the rate.
// Reset clears the queue and response valid; SCL and SDA come out of reset released high.
// rsp_stall holds the response register; req_stall rises once the two-entry queue
// behind it is full.
module i2c_master_phase_sequencer import i2cps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  item_t front_item;
  item_t head_item;
  logic  queue_full;
  logic  head_valid;
  logic  pop;
  logic  push;

  assign req_stall = queue_full;
  assign push      = req_valid && !queue_full;

  i2cps_front u_front (
    .req  (req),
    .item (front_item)
  );

  i2cps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  i2cps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

// ----- sim/i2c_master_phase_sequencer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master phase sequencer: random beats, line predictor.
module i2c_master_phase_sequencer_tb;
  import i2cps_pkg::*;

  // Operation code seven carries no command and counts as a tick
  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam int unsigned PATTERN_PHASES [8] = '{0, 3, 3, 25, 33, 5, 6, 0};
  localparam int unsigned RANDOM_BEATS = 980;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t pending_beats [$];
  rsp_t expected_line_states [$];
  int unsigned beats_total = 0;
  int unsigned beats_taken = 0;
  int unsigned error_count = 0;
  logic req_took = 1'b0;

  // Predicted line state of the sequencer
  cmd_t line_cmd = CMD_IDLE;
  logic [5:0] line_phase = '0;
  logic [7:0] line_shift = '0;
  logic [7:0] line_read_byte = '0;
  logic line_scl = 1'b1;
  logic line_sda = 1'b1;
  logic line_ack_seen = 1'b0;
  logic line_ack_drive = 1'b0;

  // Driver burst and receiver stall bookkeeping
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_tick = 0;

  i2c_master_phase_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request beat to the predicted line state and give its response
  task automatic advance_line_model(input req_t beat, output rsp_t res);
    logic [2:0] op;
    logic refused;
    logic finished;
    logic [1:0] sub;
    op = beat.operation;
    refused = 1'b0;
    finished = 1'b0;
    if (op >= OP_START && op <= OP_CACK) begin
      if (line_cmd != CMD_IDLE) begin
        refused = 1'b1;
      end else begin
        line_cmd = cmd_t'(op);
        line_phase = '0;
        if (op == OP_WRITE) line_shift = beat.data_byte;
        else if (op == OP_READ) line_shift = '0;
        else if (op == OP_SACK) line_ack_drive = beat.ack_level;
      end
    end else if (line_cmd != CMD_IDLE) begin
      line_phase = line_phase + 6'd1;
      case (line_cmd)
        CMD_START: begin
          if (line_phase == 6'd1) begin
            line_sda = 1'b1;
            line_scl = 1'b1;
          end else if (line_phase == 6'd2) line_sda = 1'b0;
          else line_scl = 1'b0;
        end
        CMD_STOP: begin
          if (line_phase == 6'd2) line_scl = 1'b1;
          else if (line_phase == 6'd3) line_sda = 1'b1;
        end
        CMD_WRITE: begin
          // three phases per bit: present data, raise SCL, drop SCL
          if (line_phase >= 6'd2) begin
            case ((line_phase - 6'd2) % 3)
              0: begin
                line_sda = line_shift[7];
                line_shift = line_shift << 1;
              end
              1: line_scl = 1'b1;
              default: line_scl = 1'b0;
            endcase
          end
        end
        CMD_READ: begin
          if (line_phase == READ_LAST_PHASE) begin
            line_scl = 1'b0;
            line_read_byte = line_shift;
          end else begin
            sub = line_phase[1:0] - 2'd1;
            if (line_phase == 6'd1) line_sda = 1'b1;
            if (sub == READ_SUB_LOW) line_scl = 1'b0;
            else if (sub == READ_SUB_HIGH) line_scl = 1'b1;
            else if (sub == READ_SUB_SAMPLE) line_shift = {line_shift[6:0], beat.sda_in};
          end
        end
        CMD_SACK: begin
          if (line_phase == 6'd1) line_scl = 1'b0;
          else if (line_phase == 6'd2) begin
            line_sda = ~line_ack_drive;
            line_scl = 1'b0;
          end else if (line_phase == 6'd3) line_scl = 1'b1;
          else if (line_phase == 6'd4) line_scl = 1'b0;
          else line_sda = 1'b1;
        end
        CMD_CACK: begin
          if (line_phase == 6'd1) line_sda = 1'b1;
          else if (line_phase == 6'd2) line_scl = 1'b0;
          else if (line_phase == 6'd3) line_scl = 1'b1;
          else if (line_phase == 6'd4) line_ack_seen = ~beat.sda_in;
          else if (line_phase == 6'd5) line_scl = 1'b0;
          else line_sda = 1'b0;
        end
        default: ;
      endcase
      if (line_phase >= PATTERN_PHASES[line_cmd]) begin
        finished = 1'b1;
        line_cmd = CMD_IDLE;
        line_phase = '0;
      end
    end
    res.scl_level = line_scl;
    res.sda_level = line_sda;
    res.busy_res = (line_cmd != CMD_IDLE);
    res.done_res = finished;
    res.read_data = line_read_byte;
    res.ack_received = line_ack_seen;
    res.rejected = refused;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic push_beat(input logic [2:0] op, input logic [7:0] data, input logic ack,
                           input logic sda);
    req_t beat;
    beat.operation = op;
    beat.data_byte = data;
    beat.ack_level = ack;
    beat.sda_in = sda;
    pending_beats.push_back(beat);
  endtask

  task automatic push_command(input logic [2:0] op, input logic [7:0] data, input logic ack);
    push_beat(op, data, ack, 1'($urandom));
  endtask

  // sda_mode: 0 holds SDA low, 1 holds it high, 2 randomises it
  task automatic push_ticks(input int unsigned count, input int unsigned sda_mode);
    logic [2:0] op;
    logic sda;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_TICK;
      sda = (sda_mode == 2) ? 1'($urandom) : sda_mode[0];
      push_beat(op, 8'($urandom), 1'($urandom), sda);
    end
  endtask

  // Fill the beat queue, run reset, then wait for the pipe to drain
  initial begin
    int unsigned counted;
    int unsigned sel;
    int unsigned len;
    int unsigned cut;
    logic [2:0] op;

    // directed: idle ticks, each command, extremes of the fields
    push_beat(OP_TICK, 8'h00, 1'b0, 1'b0);
    push_beat(OP_SPARE, 8'hFF, 1'b1, 1'b1);
    push_command(OP_START, 8'h00, 1'b0);
    push_ticks(3, 2);
    push_command(OP_WRITE, 8'hFF, 1'b1);
    push_ticks(10, 2);
    push_command(OP_READ, 8'h5A, 1'b0);
    push_ticks(15, 2);
    push_command(OP_WRITE, 8'h00, 1'b0);
    push_ticks(25, 2);
    push_command(OP_READ, 8'h00, 1'b0);
    push_ticks(33, 1);
    push_command(OP_READ, 8'hFF, 1'b1);
    push_ticks(33, 0);
    push_command(OP_SACK, 8'h00, 1'b1);
    push_ticks(5, 2);
    push_command(OP_SACK, 8'hFF, 1'b0);
    push_ticks(5, 2);
    push_command(OP_CACK, 8'h00, 1'b0);
    push_ticks(6, 0);
    push_command(OP_CACK, 8'h00, 1'b0);
    push_ticks(6, 1);
    push_command(OP_STOP, 8'h00, 1'b0);
    push_ticks(3, 2);

    // random: mostly whole commands (some with a refused command mid-pattern), some truncated ones, some idle noise
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      sel = $urandom_range(0, 19);
      op = 3'($urandom_range(OP_START, OP_CACK));
      len = PATTERN_PHASES[op];
      if (sel == 0) begin
        push_ticks($urandom_range(1, 3), 2);
      end else if (sel == 1) begin
        cut = $urandom_range(0, len - 1);
        push_command(op, 8'($urandom), 1'($urandom));
        push_ticks(cut, 2);
        counted += cut + 1;
      end else begin
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : len;
        push_command(op, 8'($urandom), 1'($urandom));
        push_ticks(cut, 2);
        if (cut != len) begin
          push_command(3'($urandom_range(OP_START, OP_CACK)), 8'($urandom), 1'($urandom));
          push_ticks(len - cut, 2);
          counted++;
        end
        counted += len + 1;
      end
    end
    beats_total = pending_beats.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_taken < beats_total) @(posedge clk);
    while (expected_line_states.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Drive request beats in bursts; hold a stalled beat
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (gap_left > 0 || pending_beats.size() == 0) begin
        req_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        req <= pending_beats.pop_front();
        req_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Stall responses: free flow, random stalls or a fixed duty pattern
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_hold = $urandom_range(50, 250);
      end else begin
        stall_hold--;
      end
      stall_tick++;
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 2) == 0);
        default: rsp_stall <= ((stall_tick % 7) < 3);
      endcase
    end
  end

  // Predict on each accepted request beat; check each accepted response beat
  always @(posedge clk) begin : watch_beats
    rsp_t want;
    rsp_t predicted;
    if (rst) begin
      req_took <= 1'b0;
    end else begin
      req_took <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (expected_line_states.size() == 0) begin
          $display("%0t: unexpected response beat, expected none, got %h", $time, rsp);
          error_count++;
        end else begin
          want = expected_line_states.pop_front();
          check_field("scl_level", want.scl_level, rsp.scl_level);
          check_field("sda_level", want.sda_level, rsp.sda_level);
          check_field("busy_res", want.busy_res, rsp.busy_res);
          check_field("done_res", want.done_res, rsp.done_res);
          check_field("read_data", want.read_data, rsp.read_data);
          check_field("ack_received", want.ack_received, rsp.ack_received);
          check_field("rejected", want.rejected, rsp.rejected);
        end
      end
      if (req_valid && !req_stall) begin
        advance_line_model(req, predicted);
        expected_line_states.push_back(predicted);
        beats_taken++;
      end
    end
  end

  // Give up well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
